### src/spfq_pkg.sv
`default_nettype none

package spfq_pkg;

   localparam int MODE_W = 2;
   localparam int ID_W   = 16;
   localparam int AGE_W  = 7;
   localparam int LVL_W  = 3;
   localparam int MIN_W  = 11;
   localparam int STAT_W = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CALL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [AGE_W-1:0] age;
      logic [LVL_W-1:0] lvl;
      logic [MIN_W-1:0] minute;
   } rec_type;

endpackage

`default_nettype wire

### src/strict_priority_five_level_queue_core.sv
// channel | dir | handshake            | word
// req_    | in  | req_valid/req_ready  | mode, record_id, age, level, arrival_minute
// rsp_    | out | rsp_valid/rsp_ready  | status, out_id, out_age, out_level, out_minute
//
// Insert ends early when the pool is full, call when all levels are empty; an unused
// mode goes straight to the hand-over in S_EMIT.
// Search reads one pooled record per cycle from the record/link memory port, and a
// word is handed over in S_EMIT once the record is found or the levels run out.
// Synchronous reset empties all levels and the pool at once; no clearing pass.
// One word at a time; a new word is taken while the last result still waits on rsp_,
// and a second finished result holds the core until rsp_ drains.
`default_nettype none

module strict_priority_five_level_queue_core #(
   parameter int NUM_LEVELS = 5,
   parameter int POOL_DEPTH = 64
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [spfq_pkg::MODE_W-1:0]     req_mode,
   input  wire  [spfq_pkg::ID_W-1:0]       req_record_id,
   input  wire  [spfq_pkg::AGE_W-1:0]      req_age,
   input  wire  [spfq_pkg::LVL_W-1:0]      req_level,
   input  wire  [spfq_pkg::MIN_W-1:0]      req_arrival_minute,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic [spfq_pkg::STAT_W-1:0]     rsp_status,
   output logic [spfq_pkg::ID_W-1:0]       rsp_out_id,
   output logic [spfq_pkg::AGE_W-1:0]      rsp_out_age,
   output logic [spfq_pkg::LVL_W-1:0]      rsp_out_level,
   output logic [spfq_pkg::MIN_W-1:0]      rsp_out_minute
);

   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int LW = $clog2(NUM_LEVELS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS,
      S_INS_POP,
      S_INS_WR,
      S_CALL,
      S_CALL_RD,
      S_SRCH,
      S_SRCH_CMP,
      S_EMIT
   } state_type;

   // memories
   spfq_pkg::rec_type record_mem [POOL_DEPTH];
   logic [AW-1:0]     link_mem   [POOL_DEPTH];
   logic [AW-1:0]     free_mem   [POOL_DEPTH];

   state_type                     state_ff, state_in;
   spfq_pkg::rec_type             req_rec_ff, req_rec_in;
   logic [AW-1:0]                 head_ff [NUM_LEVELS];
   logic [AW-1:0]                 head_in [NUM_LEVELS];
   logic [AW-1:0]                 tail_ff [NUM_LEVELS];
   logic [AW-1:0]                 tail_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0]         nonempty_ff, nonempty_in;
   logic [CW-1:0]                 fresh_ff, fresh_in;     // never-used entries handed out
   logic [CW-1:0]                 stack_ff, stack_in;     // recycled entries on free stack
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [LW-1:0]                 cur_ff, cur_in;
   logic [spfq_pkg::STAT_W-1:0]   res_status_ff, res_status_in;
   spfq_pkg::rec_type             res_rec_ff, res_rec_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [spfq_pkg::STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   spfq_pkg::rec_type             rsp_rec_ff, rsp_rec_in;

   spfq_pkg::rec_type             rec_rd_ff;
   logic [AW-1:0]                 link_rd_ff;
   logic [AW-1:0]                 free_rd_ff;

   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic                          rec_we;
   logic                          link_we;
   logic [AW-1:0]                 link_waddr;
   logic                          free_we;
   logic                          free_rd_en;
   logic [AW-1:0]                 free_rd_addr;

   logic [spfq_pkg::LVL_W-1:0]    lvl_sat;
   logic [LW-1:0]                 lvl_idx;
   logic                          first_found;
   logic [LW-1:0]                 first_lvl;
   logic                          next_found;
   logic [LW-1:0]                 next_lvl;
   logic                          can_emit;
   logic                          pool_full;

   assign lvl_sat = (int'(req_level) >= NUM_LEVELS) ?
                    spfq_pkg::LVL_W'(NUM_LEVELS - 1) : req_level;
   assign lvl_idx   = LW'(req_rec_ff.lvl);
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign pool_full = (fresh_ff == CW'(POOL_DEPTH)) && (stack_ff == '0);

   // lowest nonempty level, and lowest nonempty level above cur_ff
   always_comb begin
      first_found = 1'b0;
      first_lvl   = '0;
      next_found  = 1'b0;
      next_lvl    = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            first_found = 1'b1;
            first_lvl   = LW'(i);
         end
         if (nonempty_ff[i] && (LW'(i) > cur_ff)) begin
            next_found = 1'b1;
            next_lvl   = LW'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_rec_in    = req_rec_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      nonempty_in   = nonempty_ff;
      fresh_in      = fresh_ff;
      stack_in      = stack_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      rec_we        = 1'b0;
      link_we       = 1'b0;
      link_waddr    = '0;
      free_we       = 1'b0;
      free_rd_en    = 1'b0;
      free_rd_addr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_rec_in.id     = req_record_id;
               req_rec_in.age    = req_age;
               req_rec_in.lvl    = lvl_sat;
               req_rec_in.minute = req_arrival_minute;
               res_status_in     = spfq_pkg::STAT_OK;
               res_rec_in        = '0;
               unique case (req_mode)
                  spfq_pkg::MODE_INSERT: state_in = S_INS;
                  spfq_pkg::MODE_CALL:   state_in = S_CALL;
                  spfq_pkg::MODE_SEARCH: state_in = S_SRCH;
                  default:               state_in = S_EMIT;
               endcase
            end
         end
         S_INS: begin
            if (pool_full) begin
               res_status_in = spfq_pkg::STAT_FULL;
               state_in      = S_EMIT;
            end else if (stack_ff != '0) begin
               free_rd_en   = 1'b1;
               free_rd_addr = AW'(stack_ff - 1'b1);
               stack_in     = stack_ff - 1'b1;
               state_in     = S_INS_POP;
            end else begin
               idx_in   = AW'(fresh_ff);
               fresh_in = fresh_ff + 1'b1;
               state_in = S_INS_WR;
            end
         end
         S_INS_POP: begin
            idx_in   = free_rd_ff;
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            rec_we = 1'b1;
            // tail's link is only written when a successor arrives
            if (nonempty_ff[lvl_idx]) begin
               link_we    = 1'b1;
               link_waddr = tail_ff[lvl_idx];
            end else begin
               head_in[lvl_idx] = idx_ff;
            end
            tail_in[lvl_idx]     = idx_ff;
            nonempty_in[lvl_idx] = 1'b1;
            state_in             = S_EMIT;
         end
         S_CALL: begin
            if (!first_found) begin
               res_status_in = spfq_pkg::STAT_EMPTY;
               state_in      = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff[first_lvl];
               idx_in   = head_ff[first_lvl];
               cur_in   = first_lvl;
               state_in = S_CALL_RD;
            end
         end
         S_CALL_RD: begin
            res_rec_in = rec_rd_ff;
            if (idx_ff == tail_ff[cur_ff]) begin
               nonempty_in[cur_ff] = 1'b0;
            end else begin
               head_in[cur_ff] = link_rd_ff;
            end
            free_we  = 1'b1;
            stack_in = stack_ff + 1'b1;
            state_in = S_EMIT;
         end
         S_SRCH: begin
            if (!first_found) begin
               res_status_in = spfq_pkg::STAT_NOT_FOUND;
               state_in      = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff[first_lvl];
               idx_in   = head_ff[first_lvl];
               cur_in   = first_lvl;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (rec_rd_ff.id == req_rec_ff.id) begin
               res_rec_in = rec_rd_ff;
               state_in   = S_EMIT;
            end else if (idx_ff == tail_ff[cur_ff]) begin
               if (next_found) begin
                  rd_en   = 1'b1;
                  rd_addr = head_ff[next_lvl];
                  idx_in  = head_ff[next_lvl];
                  cur_in  = next_lvl;
               end else begin
                  res_status_in = spfq_pkg::STAT_NOT_FOUND;
                  state_in      = S_EMIT;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = link_rd_ff;
               idx_in  = link_rd_ff;
            end
         end
         S_EMIT: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rec_in    = res_rec_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_rec_ff    <= req_rec_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         nonempty_ff  <= '0;
         fresh_ff     <= '0;
         stack_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         fresh_ff     <= fresh_in;
         stack_ff     <= stack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // record and link memories share one read address
   always_ff @(posedge clock) begin
      if (rec_we) begin
         record_mem[idx_ff] <= req_rec_ff;
      end
      if (link_we) begin
         link_mem[link_waddr] <= idx_ff;
      end
      if (rd_en) begin
         rec_rd_ff  <= record_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[AW'(stack_ff)] <= idx_ff;
      end
      if (free_rd_en) begin
         free_rd_ff <= free_mem[free_rd_addr];
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_id     = rsp_rec_ff.id;
   assign rsp_out_age    = rsp_rec_ff.age;
   assign rsp_out_level  = rsp_rec_ff.lvl;
   assign rsp_out_minute = rsp_rec_ff.minute;

   // recycled entries can never outnumber those handed out
   a_free_accounting: assert property (@(posedge clock) disable iff (reset)
      (stack_ff <= fresh_ff) && (fresh_ff <= CW'(POOL_DEPTH)))
      else $error("free pool accounting broken");

   a_walk_level_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_CMP || state_ff == S_CALL_RD) |-> nonempty_ff[cur_ff])
      else $error("walking an empty level");

   a_insert_marks_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WR) |=> nonempty_ff[lvl_idx])
      else $error("insert left its level empty");

   a_search_no_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_CMP) |=> ($stable(nonempty_ff) && $stable(stack_ff)))
      else $error("queue state changed during search");

endmodule

`default_nettype wire
